FILE: design/ordered_array_list_engine_defines.svh
// assertion macros for the ordered array list engine
// each macro expects clk and arst_n in the scope where it is used
`ifndef ORDERED_ARRAY_LIST_ENGINE_DEFINES_SVH
`define ORDERED_ARRAY_LIST_ENGINE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define OALE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("oale assertion failed");
// next-cycle implication
`define OALE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("oale assertion failed");
`else
`define OALE_ASSERT_NOW(label, ante, cons)
`define OALE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: design/oale_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package oale_pkg;

	// list geometry and fixed field widths
	localparam int CAPACITY    = 64;
	localparam int DATA_W      = 32;
	localparam int POS_W       = 7;
	localparam int IDX_W       = 6;
	localparam int CNT_W       = 7;
	localparam int QUEUE_DEPTH = 2;

	// request codes as they arrive
	typedef enum logic [2:0] {
		REQ_INSERT     = 3'd0,
		REQ_ERASE      = 3'd1,
		REQ_FIND       = 3'd2,
		REQ_PUSH_BACK  = 3'd3,
		REQ_PUSH_FRONT = 3'd4,
		REQ_POP_BACK   = 3'd5,
		REQ_POP_FRONT  = 3'd6
	} req_code_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD       = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// classified operation handed to the back end
	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_ERASE  = 2'd1,
		OP_FIND   = 2'd2,
		OP_BAD    = 2'd3
	} op_t;

	typedef struct packed {
		req_code_t                 req_type;
		logic [POS_W-1:0]          position;
		logic signed [DATA_W-1:0]  value;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [IDX_W-1:0]  found_index;
		logic [CNT_W-1:0]  count;
	} rsp_t;

	// at_end: position is taken from the list end at execution time
	typedef struct packed {
		op_t                       op;
		logic                      at_end;
		logic [POS_W-1:0]          pos;
		logic signed [DATA_W-1:0]  value;
	} cmd_t;

endpackage

`default_nettype wire

FILE: design/oale_front.sv
`timescale 1ns / 1ps
`default_nettype none

module oale_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	output logic                full,
	input  wire oale_pkg::req_t request,
	output logic                cmd_valid,
	input  wire logic           cmd_take,
	output oale_pkg::cmd_t      cmd
);

	oale_pkg::cmd_t dec;
	oale_pkg::cmd_t buf_q [oale_pkg::QUEUE_DEPTH];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     fill_q;
	logic           wr_en;
	logic           rd_en;

	// map each request kind onto insert, erase or find, and unknown codes onto bad
	always_comb begin
		dec.op     = oale_pkg::OP_BAD;
		dec.at_end = 1'b0;
		dec.pos    = request.position;
		dec.value  = request.value;
		unique case (request.req_type)
			oale_pkg::REQ_INSERT: begin
				dec.op = oale_pkg::OP_INSERT;
			end
			oale_pkg::REQ_ERASE: begin
				dec.op = oale_pkg::OP_ERASE;
			end
			oale_pkg::REQ_FIND: begin
				dec.op = oale_pkg::OP_FIND;
			end
			oale_pkg::REQ_PUSH_BACK: begin
				dec.op     = oale_pkg::OP_INSERT;
				dec.at_end = 1'b1;
			end
			oale_pkg::REQ_PUSH_FRONT: begin
				dec.op  = oale_pkg::OP_INSERT;
				dec.pos = '0;
			end
			oale_pkg::REQ_POP_BACK: begin
				dec.op     = oale_pkg::OP_ERASE;
				dec.at_end = 1'b1;
			end
			oale_pkg::REQ_POP_FRONT: begin
				dec.op  = oale_pkg::OP_ERASE;
				dec.pos = '0;
			end
			default: begin
				dec.op = oale_pkg::OP_BAD;
			end
		endcase
	end

	// command queue handshake
	assign full      = (fill_q == 2'(oale_pkg::QUEUE_DEPTH));
	assign cmd_valid = (fill_q != 2'd0);
	assign wr_en     = push && !full;
	assign rd_en     = cmd_take && cmd_valid;
	assign cmd       = buf_q[rd_ptr_q];

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (wr_en)
				wr_ptr_q <= !wr_ptr_q;
			if (rd_en)
				rd_ptr_q <= !rd_ptr_q;
			if (wr_en && !rd_en)
				fill_q <= fill_q + 2'd1;
			else if (rd_en && !wr_en)
				fill_q <= fill_q - 2'd1;
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (wr_en)
			buf_q[wr_ptr_q] <= dec;
	end

endmodule

`default_nettype wire

FILE: design/oale_back.sv
`timescale 1ns / 1ps
`default_nettype none

module oale_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	input  wire oale_pkg::cmd_t cmd,
	output logic                cmd_take,
	output logic                empty,
	input  wire logic           pop,
	output oale_pkg::rsp_t      result
);

	localparam logic [oale_pkg::CNT_W-1:0] CAP_CNT = oale_pkg::CNT_W'(oale_pkg::CAPACITY);

	logic signed [oale_pkg::DATA_W-1:0] store_q [oale_pkg::CAPACITY];
	logic [oale_pkg::CNT_W-1:0]         count_q;

	logic [oale_pkg::CNT_W-1:0]         pos_eff;
	logic                               ins_ok;
	logic                               era_ok;
	oale_pkg::status_t                  status_d;
	logic [oale_pkg::CNT_W-1:0]         count_d;
	logic [oale_pkg::CAPACITY-1:0]      match_d;

	logic                               valid_s2;
	logic                               find_s2;
	logic [oale_pkg::CAPACITY-1:0]      match_s2;
	oale_pkg::status_t                  status_s2;
	logic [oale_pkg::CNT_W-1:0]         count_s2;

	logic [oale_pkg::IDX_W-1:0]         first_idx;
	oale_pkg::rsp_t                     rsp_d;

	oale_pkg::rsp_t                     rbuf_q [oale_pkg::QUEUE_DEPTH];
	logic                               rwr_q;
	logic                               rrd_q;
	logic [1:0]                         rfill_q;
	logic                               res_full;
	logic                               s2_move;
	logic                               rd_en;

	// flow control between execute, encode and result queue
	assign res_full = (rfill_q == 2'(oale_pkg::QUEUE_DEPTH));
	assign s2_move  = valid_s2 && !res_full;
	assign cmd_take = cmd_valid && (!valid_s2 || s2_move);
	assign empty    = (rfill_q == 2'd0);
	assign rd_en    = pop && !empty;
	assign result   = rbuf_q[rrd_q];

	// resolve end-relative positions and check bounds
	always_comb begin
		pos_eff = cmd.pos;
		if (cmd.at_end) begin
			if (cmd.op == oale_pkg::OP_INSERT)
				pos_eff = count_q;
			else
				pos_eff = count_q - oale_pkg::CNT_W'(1);
		end
		ins_ok = (pos_eff <= count_q) && (count_q < CAP_CNT);
		era_ok = (pos_eff < count_q);
	end

	// status and new count of the executing command
	always_comb begin
		status_d = oale_pkg::ST_BAD;
		count_d  = count_q;
		unique case (cmd.op)
			oale_pkg::OP_INSERT: begin
				if (pos_eff > count_q)
					status_d = oale_pkg::ST_BAD;
				else if (count_q >= CAP_CNT)
					status_d = oale_pkg::ST_FULL;
				else begin
					status_d = oale_pkg::ST_OK;
					count_d  = count_q + oale_pkg::CNT_W'(1);
				end
			end
			oale_pkg::OP_ERASE: begin
				if (era_ok) begin
					status_d = oale_pkg::ST_OK;
					count_d  = count_q - oale_pkg::CNT_W'(1);
				end
			end
			oale_pkg::OP_FIND: begin
				status_d = oale_pkg::ST_NOT_FOUND;
			end
			default: begin
				status_d = oale_pkg::ST_BAD;
			end
		endcase
	end

	// parallel compare against every live entry
	always_comb begin
		for (int i = 0; i < oale_pkg::CAPACITY; i++)
			match_d[i] = (oale_pkg::CNT_W'(i) < count_q) && (store_q[i] == cmd.value);
	end

	// list count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else if (cmd_take)
			count_q <= count_d;
	end

	// entry chain: shift up on insert, down on erase
	always_ff @(posedge clk) begin
		if (cmd_take && cmd.op == oale_pkg::OP_INSERT && ins_ok) begin
			for (int i = 1; i < oale_pkg::CAPACITY; i++) begin
				if (oale_pkg::CNT_W'(i) > pos_eff)
					store_q[i] <= store_q[i-1];
			end
			for (int i = 0; i < oale_pkg::CAPACITY; i++) begin
				if (oale_pkg::CNT_W'(i) == pos_eff)
					store_q[i] <= cmd.value;
			end
		end else if (cmd_take && cmd.op == oale_pkg::OP_ERASE && era_ok) begin
			for (int i = 0; i < oale_pkg::CAPACITY - 1; i++) begin
				if (oale_pkg::CNT_W'(i) >= pos_eff)
					store_q[i] <= store_q[i+1];
			end
		end
	end

	// encode stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (cmd_take)
			valid_s2 <= 1'b1;
		else if (s2_move)
			valid_s2 <= 1'b0;
	end

	// encode stage payload
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			find_s2   <= (cmd.op == oale_pkg::OP_FIND);
			match_s2  <= match_d;
			status_s2 <= status_d;
			count_s2  <= count_d;
		end
	end

	// first matching position, lowest index wins
	always_comb begin
		first_idx = '0;
		for (int i = oale_pkg::CAPACITY - 1; i >= 0; i--) begin
			if (match_s2[i])
				first_idx = oale_pkg::IDX_W'(i);
		end
	end

	// assemble the result beat
	always_comb begin
		rsp_d.status      = status_s2;
		rsp_d.found_index = '0;
		rsp_d.count       = count_s2;
		if (find_s2 && (|match_s2)) begin
			rsp_d.status      = oale_pkg::ST_OK;
			rsp_d.found_index = first_idx;
		end
	end

	// result queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rwr_q   <= 1'b0;
			rrd_q   <= 1'b0;
			rfill_q <= 2'd0;
		end else begin
			if (s2_move)
				rwr_q <= !rwr_q;
			if (rd_en)
				rrd_q <= !rrd_q;
			if (s2_move && !rd_en)
				rfill_q <= rfill_q + 2'd1;
			else if (rd_en && !s2_move)
				rfill_q <= rfill_q - 2'd1;
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (s2_move)
			rbuf_q[rwr_q] <= rsp_d;
	end

endmodule

`default_nettype wire

FILE: design/ordered_array_list_engine.sv
// Ordered list of up to 64 signed 32-bit values with insert, erase, find,
// push and pop requests; every request returns exactly one result beat with
// status, index of the first match and the count after the request. A new
// request can be taken every clock cycle while the command queue is not full
// and one result can leave every cycle while the result queue is not empty;
// a request passes through the two-entry command queue, the execute step on
// the shifting entry chain with its parallel compare, and the registered
// first-match encoder ahead of the two-entry result queue. No clearing pass
// is needed after reset: only the count is cleared.
`timescale 1ns / 1ps
`default_nettype none

`include "ordered_array_list_engine_defines.svh"

module ordered_array_list_engine (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	output logic                full,
	input  wire oale_pkg::req_t request,
	output logic                empty,
	input  wire logic           pop,
	output oale_pkg::rsp_t      result
);

	logic           cmd_valid;
	logic           cmd_take;
	oale_pkg::cmd_t cmd;

	// request decode and command queue
	oale_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.request   (request),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.cmd       (cmd)
	);

	// list storage, execution and result queue
	oale_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	// result sanity checks
	`OALE_ASSERT_NOW(a_count_in_range, !empty, result.count <= oale_pkg::CNT_W'(oale_pkg::CAPACITY))
	`OALE_ASSERT_NOW(a_index_only_on_find, !empty && result.status != oale_pkg::ST_OK, result.found_index == '0)
	`OALE_ASSERT_NOW(a_full_status_at_capacity, !empty && result.status == oale_pkg::ST_FULL, result.count == oale_pkg::CNT_W'(oale_pkg::CAPACITY))
	// an executed command passes through the encode stage register before its beat is queued
	`OALE_ASSERT_NEXT(a_cmd_reaches_result, cmd_take, ##1 !empty)

endmodule

`default_nettype wire

FILE: tb/ordered_array_list_engine_tb.sv
`timescale 1ns / 1ps

import oale_pkg::*;

// shadow copy of the list plus the queue of result beats still owed by the block
class list_scoreboard;
	logic signed [DATA_W-1:0] shadow_list [CAPACITY];
	int shadow_count;
	rsp_t pending_results [$];
	int errors;
	int accepted;
	int checked;
	int times_full;
	int status_seen [4];

	function status_t insert_at(int pos, logic signed [DATA_W-1:0] v);
		// position is checked before fullness
		if (pos > shadow_count)
			return ST_BAD;
		if (shadow_count >= CAPACITY)
			return ST_FULL;
		for (int i = shadow_count; i > pos; i--)
			shadow_list[i] = shadow_list[i - 1];
		shadow_list[pos] = v;
		shadow_count++;
		if (shadow_count == CAPACITY)
			times_full++;
		return ST_OK;
	endfunction

	function status_t erase_at(int pos);
		if (pos >= shadow_count)
			return ST_BAD;
		for (int i = pos + 1; i < shadow_count; i++)
			shadow_list[i - 1] = shadow_list[i];
		shadow_count--;
		return ST_OK;
	endfunction

	// apply one accepted request beat and queue the result it must produce
	function void note_request(req_t r);
		rsp_t rsp;
		rsp.status = ST_BAD;
		rsp.found_index = '0;
		case (r.req_type)
			REQ_INSERT:     rsp.status = insert_at(int'(r.position), r.value);
			REQ_ERASE:      rsp.status = erase_at(int'(r.position));
			REQ_FIND: begin
				rsp.status = ST_NOT_FOUND;
				for (int i = 0; i < shadow_count; i++) begin
					if (rsp.status == ST_NOT_FOUND && shadow_list[i] == r.value) begin
						rsp.status = ST_OK;
						rsp.found_index = i[IDX_W-1:0];
					end
				end
			end
			REQ_PUSH_BACK:  rsp.status = insert_at(shadow_count, r.value);
			REQ_PUSH_FRONT: rsp.status = insert_at(0, r.value);
			REQ_POP_BACK:   rsp.status = (shadow_count == 0) ? ST_BAD : erase_at(shadow_count - 1);
			REQ_POP_FRONT:  rsp.status = erase_at(0);
			default:        rsp.status = ST_BAD;
		endcase
		rsp.count = shadow_count[CNT_W-1:0];
		status_seen[rsp.status]++;
		accepted++;
		pending_results.push_back(rsp);
	endfunction

	// compare one result beat against the oldest owed result
	function void check_result(rsp_t got);
		rsp_t want;
		if (pending_results.size() == 0) begin
			$error("result beat with nothing owed: status %0d index %0d count %0d",
				got.status, got.found_index, got.count);
			errors++;
			return;
		end
		want = pending_results.pop_front();
		checked++;
		if (got.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, got.status);
			errors++;
		end
		if (got.found_index !== want.found_index) begin
			$error("found_index: expected %0d, got %0d", want.found_index, got.found_index);
			errors++;
		end
		if (got.count !== want.count) begin
			$error("count: expected %0d, got %0d", want.count, got.count);
			errors++;
		end
	endfunction
endclass

module ordered_array_list_engine_tb;

	localparam logic [2:0] REQ_UNUSED = 3'd7;
	localparam int RANDOM_ITEMS = 1800;
	localparam int BURST_MAX    = 200;
	localparam int MIX_LEN      = 40;
	localparam int TAIL_CYCLES  = 8;
	localparam int CYCLE_LIMIT  = 400000;

	typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} burst_t;

	logic clk = 1'b0;
	logic arst_n;
	logic push;
	logic full;
	req_t request;
	logic empty;
	logic pop;
	rsp_t result;

	list_scoreboard board = new();
	int send_idle_pct;
	int recv_stall_pct;
	int random_sent;
	int cycles;

	ordered_array_list_engine dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.request (request),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL ordered_array_list_engine");
			$finish;
		end
	end

	// result side: check every popped beat, stall at random
	initial begin
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			if (pop && !empty)
				board.check_result(result);
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic req_t make_req(req_code_t code, int pos, logic [DATA_W-1:0] v);
		req_t r;
		r.req_type = code;
		r.position = pos[POS_W-1:0];
		r.value = v;
		return r;
	endfunction

	// small values collide often, extremes cover every bit
	function automatic logic [DATA_W-1:0] random_value();
		logic [DATA_W-1:0] v;
		case ($urandom_range(3))
			0: v = $urandom_range(8) - 4;
			1: begin
				case ($urandom_range(3))
					0: v = 32'h8000_0000;
					1: v = 32'h7fff_ffff;
					2: v = '0;
					default: v = '1;
				endcase
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// fill and drain bursts favor growing or shrinking the list
	function automatic req_t random_request(burst_t mode);
		req_t r;
		int roll;
		int cnt;
		cnt = board.shadow_count;
		roll = $urandom_range(99);
		if (mode == MODE_MIX || roll >= 95)
			r.req_type = req_code_t'($urandom_range(7));
		else if (roll >= 80)
			r.req_type = REQ_FIND;
		else if (mode == MODE_FILL) begin
			case ($urandom_range(2))
				0: r.req_type = REQ_INSERT;
				1: r.req_type = REQ_PUSH_BACK;
				default: r.req_type = REQ_PUSH_FRONT;
			endcase
		end else begin
			case ($urandom_range(2))
				0: r.req_type = REQ_ERASE;
				1: r.req_type = REQ_POP_BACK;
				default: r.req_type = REQ_POP_FRONT;
			endcase
		end
		r.value = random_value();
		// finds mostly look for something that is there
		if (r.req_type == REQ_FIND && cnt > 0 && $urandom_range(9) < 7)
			r.value = board.shadow_list[$urandom_range(cnt - 1)];
		// positions mostly in range, sometimes anywhere in the field
		if ($urandom_range(9) < 8) begin
			if (r.req_type == REQ_ERASE && cnt > 0)
				r.position = POS_W'($urandom_range(cnt - 1));
			else
				r.position = POS_W'($urandom_range(cnt));
		end else
			r.position = POS_W'($urandom_range(127));
		return r;
	endfunction

	// one request beat, with random idle cycles ahead of it
	task automatic send_request(input req_t r);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		push <= 1'b1;
		request <= r;
		do @(posedge clk); while (full);
		board.note_request(r);
	endtask

	// hold off until every owed result has come back
	task automatic wait_for_results();
		push <= 1'b0;
		do @(posedge clk); while (board.pending_results.size() != 0);
	endtask

	initial begin
		int burst_no;
		int left;
		burst_t mode;

		arst_n <= 1'b0;
		push <= 1'b0;
		request <= '0;
		cycles <= 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty list, extremes, duplicates, bad positions, unused code
		send_request(make_req(REQ_POP_BACK, 0, 0));
		send_request(make_req(REQ_POP_FRONT, 0, 0));
		send_request(make_req(REQ_ERASE, 0, 0));
		send_request(make_req(REQ_FIND, 0, 0));
		send_request(make_req(REQ_INSERT, 1, 9));
		send_request(make_req(req_code_t'(REQ_UNUSED), 127, 32'hffff_ffff));
		send_request(make_req(REQ_PUSH_BACK, 0, 32'h7fff_ffff));
		send_request(make_req(REQ_PUSH_FRONT, 0, 32'h8000_0000));
		send_request(make_req(REQ_INSERT, 1, 0));
		send_request(make_req(REQ_INSERT, 3, 32'hffff_ffff));
		send_request(make_req(REQ_INSERT, 127, 5));
		send_request(make_req(REQ_INSERT, 64, 5));
		send_request(make_req(REQ_FIND, 0, 32'hffff_ffff));
		send_request(make_req(REQ_FIND, 0, 32'h8000_0000));
		send_request(make_req(REQ_PUSH_BACK, 0, 0));
		send_request(make_req(REQ_FIND, 0, 0));
		send_request(make_req(REQ_FIND, 0, 12345));
		send_request(make_req(REQ_ERASE, 5, 0));
		send_request(make_req(REQ_ERASE, 127, 0));
		send_request(make_req(REQ_ERASE, 1, 0));
		send_request(make_req(REQ_POP_BACK, 0, 0));
		send_request(make_req(REQ_POP_FRONT, 0, 0));
		send_request(make_req(REQ_ERASE, 0, 0));
		send_request(make_req(REQ_POP_FRONT, 0, 0));
		send_request(make_req(REQ_FIND, 0, 0));
		wait_for_results();

		// random bursts: fill to capacity, mix, drain to empty, mix
		burst_no = 0;
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			case ((burst_no / 4) % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
				default: begin send_idle_pct = 23; recv_stall_pct = 23; end
			endcase
			case (burst_no % 4)
				0: mode = MODE_FILL;
				2: mode = MODE_DRAIN;
				default: mode = MODE_MIX;
			endcase
			left = (mode == MODE_MIX) ? MIX_LEN : BURST_MAX;
			for (int len = 0; len < left; len++) begin
				send_request(random_request(mode));
				random_sent++;
				// a few more beats past full or empty hit the corner statuses
				if (mode == MODE_FILL && board.shadow_count == CAPACITY && left > len + 7)
					left = len + 7;
				if (mode == MODE_DRAIN && board.shadow_count == 0 && left > len + 5)
					left = len + 5;
			end
			if (mode == MODE_DRAIN)
				wait_for_results();
			burst_no++;
		end

		// let the tail drain with the receiver always ready
		recv_stall_pct = 0;
		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.pending_results.size() != 0) begin
			$error("%0d result beats never arrived", board.pending_results.size());
			board.errors++;
		end

		$display("%0d requests checked: %0d ok, %0d bad position or empty, %0d full, %0d not found",
			board.checked, board.status_seen[ST_OK], board.status_seen[ST_BAD],
			board.status_seen[ST_FULL], board.status_seen[ST_NOT_FOUND]);
		$display("list reached capacity %0d times across %0d random bursts",
			board.times_full, burst_no);
		if (board.errors == 0)
			$display("PASS ordered_array_list_engine");
		else
			$display("FAIL ordered_array_list_engine");
		$finish;
	end

endmodule
